### hw/rtl/lsw_pkg.sv
`default_nettype none

package lsw_pkg;

   typedef enum logic [1:0] {
      FUNC_EXEC = 2'd0,
      FUNC_WREG = 2'd1,
      FUNC_WMEM = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   localparam logic [3:0]  PC_REG    = 4'd15;
   localparam logic [31:0] PC_OFFSET = 32'd8;

endpackage

`default_nettype wire

### hw/rtl/lsw_if.sv
`default_nettype none

interface lsw_req_if;
   logic               valid;
   logic               ready;
   lsw_pkg::func_type  func;
   logic [31:0]        instr_word;
   logic [3:0]         reg_select;
   logic [15:0]        word_index;
   logic [31:0]        load_value;

   modport source (output valid, func, instr_word, reg_select, word_index, load_value,
                   input ready);
   modport sink   (input valid, func, instr_word, reg_select, word_index, load_value,
                   output ready);
endinterface

interface lsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] dest_value;
   logic [31:0] effective_address;
   logic [31:0] new_base;
   logic        out_of_bounds;

   modport source (output valid, dest_value, effective_address, new_base, out_of_bounds,
                   input ready);
   modport sink   (input valid, dest_value, effective_address, new_base, out_of_bounds,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/load_store_word_unit_top.sv
// channel | dir | words carried
// req     | in  | func, instr_word, reg_select, word_index, load_value
// rsp     | out | dest_value, effective_address, new_base, out_of_bounds
//
// rsp valid is set from S_DONE, reached from S_IDLE for a preload, via S_SHIFT, S_ADDR, S_MEM
// for a transfer, plus S_HI for an unaligned store (registered register file and word
// memory reads, single memory write port); S_DONE waits while the rsp slot is full
// after reset a clearing pass over max(MEM_WORDS, NUM_REGS) addresses zeroes both memories
// req is held off during the pass and while a word is in flight
// a finished word waits in the rsp register while the next req is taken
`default_nettype none

module load_store_word_unit_top #(
   parameter int MEM_WORDS = 65536,
   parameter int NUM_REGS  = 16
) (
   input wire logic clock,
   input wire logic reset,
   lsw_req_if.sink   req,
   lsw_rsp_if.source rsp
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int RW = $clog2(NUM_REGS);
   localparam int CLR_N = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
   localparam int CW = $clog2(CLR_N);
   localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) * 33'd4;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SHIFT, S_ADDR, S_MEM, S_HI, S_DONE
   } state_type;

   function automatic logic [31:0] barrel(logic [31:0] v, logic [1:0] kind, logic [7:0] amt);
      logic [4:0] a;
      logic [31:0] r;
      a = amt[4:0];
      r = v;
      if (amt != 8'd0) begin
         case (kind)
            lsw_pkg::SHIFT_LSL: r = (amt >= 8'd32) ? 32'd0 : (v << a);
            lsw_pkg::SHIFT_LSR: r = (amt >= 8'd32) ? 32'd0 : (v >> a);
            lsw_pkg::SHIFT_ASR: r = $unsigned($signed(v) >>> ((amt >= 8'd32) ? 5'd31 : a));
            default:            r = (a == 5'd0) ? v : ((v >> a) | (v << (6'd32 - {1'b0, a})));
         endcase
      end
      return r;
   endfunction

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] ins_ff, ins_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] old_ff, old_in;
   logic [31:0] moved_ff, moved_in;
   logic [31:0] addr_ff, addr_in;
   logic        oob_ff, oob_in;
   logic        hiok_ff, hiok_in;
   logic [31:0] dv_ff, dv_in;
   logic [31:0] nb_ff, nb_in;
   logic [31:0] hiwr_ff, hiwr_in;
   logic        rv_ff, rv_in;
   logic [31:0] rdv_ff, rdv_in;
   logic [31:0] rea_ff, rea_in;
   logic [31:0] rnb_ff, rnb_in;
   logic        roob_ff, roob_in;

   logic          rf_we;
   logic [RW-1:0] rf_wa, rf_ra0, rf_ra1;
   logic [31:0]   rf_wd, rf_rd0, rf_rd1;
   logic          mm_we;
   logic [AW-1:0] mm_wa, mm_ra0, mm_ra1;
   logic [31:0]   mm_wd, mm_rd0, mm_rd1;

   logic [31:0] widx, a, lo, hi, ldv, rdv;
   logic [7:0]  amt;
   logic [5:0]  sh;
   logic        is_load, slot_free;

   lsw_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf (
      .clock(clock), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
      .raddr_a(rf_ra0), .raddr_b(rf_ra1), .rdata_a(rf_rd0), .rdata_b(rf_rd1)
   );

   lsw_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
      .clock(clock), .we(mm_we), .waddr(mm_wa), .wdata(mm_wd),
      .raddr_a(mm_ra0), .raddr_b(mm_ra1), .rdata_a(mm_rd0), .rdata_b(mm_rd1)
   );

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rv_ff;
   assign rsp.dest_value    = rdv_ff;
   assign rsp.effective_address = rea_ff;
   assign rsp.new_base      = rnb_ff;
   assign rsp.out_of_bounds = roob_ff;

   assign slot_free = !rv_ff || rsp.ready;
   assign is_load   = ins_ff[20];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ins_in   = ins_ff;
      off_in   = off_ff;
      base_in  = base_ff;
      old_in   = old_ff;
      moved_in = moved_ff;
      addr_in  = addr_ff;
      oob_in   = oob_ff;
      hiok_in  = hiok_ff;
      dv_in    = dv_ff;
      nb_in    = nb_ff;
      hiwr_in  = hiwr_ff;
      rv_in    = rsp.ready ? 1'b0 : rv_ff;
      rdv_in   = rdv_ff;
      rea_in   = rea_ff;
      rnb_in   = rnb_ff;
      roob_in  = roob_ff;
      rf_we  = 1'b0;
      rf_wa  = ins_ff[15:12];
      rf_wd  = 32'd0;
      rf_ra0 = req.instr_word[3:0];
      rf_ra1 = req.instr_word[11:8];
      mm_we  = 1'b0;
      mm_wa  = addr_ff[AW+1:2];
      mm_wd  = 32'd0;
      widx   = {16'd0, req.word_index};
      a      = 32'd0;
      amt    = 8'd0;
      sh     = {1'b0, addr_ff[1:0], 3'b000};
      lo     = mm_rd0;
      hi     = hiok_ff ? mm_rd1 : 32'd0;
      ldv    = (sh == 6'd0) ? lo : ((lo >> sh) | (hi << (6'd32 - sh)));
      rdv    = (is_load && !oob_ff) ? ldv : old_ff;
      mm_ra0 = a[AW+1:2];
      mm_ra1 = a[AW+1:2];
      unique case (state_ff)
         S_CLEAR: begin
            rf_we = (32'(cnt_ff) < 32'(NUM_REGS));
            rf_wa = cnt_ff[RW-1:0];
            mm_we = (32'(cnt_ff) < 32'(MEM_WORDS));
            mm_wa = cnt_ff[AW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               ins_in  = req.instr_word;
               dv_in   = 32'd0;
               nb_in   = 32'd0;
               addr_in = 32'd0;
               oob_in  = 1'b0;
               state_in = S_DONE;
               unique case (req.func)
                  lsw_pkg::FUNC_WREG: begin
                     rf_we = 1'b1;
                     rf_wa = req.reg_select;
                     rf_wd = req.load_value;
                     dv_in = req.load_value;
                  end
                  lsw_pkg::FUNC_WMEM: begin
                     if (widx < 32'(MEM_WORDS)) begin
                        mm_we = 1'b1;
                        mm_wa = widx[AW-1:0];
                        mm_wd = req.load_value;
                     end else begin
                        oob_in = 1'b1;
                     end
                  end
                  lsw_pkg::FUNC_EXEC: state_in = S_SHIFT;
                  default: ;
               endcase
            end
         end
         S_SHIFT: begin
            amt = ins_ff[4] ? rf_rd1[7:0] : {3'b000, ins_ff[11:7]};
            off_in = ins_ff[25] ? barrel(rf_rd0, ins_ff[6:5], amt) : {20'd0, ins_ff[11:0]};
            rf_ra0 = ins_ff[19:16];
            rf_ra1 = ins_ff[15:12];
            state_in = S_ADDR;
         end
         S_ADDR: begin
            base_in  = rf_rd0;
            old_in   = rf_rd1;
            moved_in = ins_ff[23] ? (rf_rd0 + off_ff) : (rf_rd0 - off_ff);
            a = ins_ff[24] ? moved_in : rf_rd0;
            if (ins_ff[19:16] == lsw_pkg::PC_REG) begin
               a = a + lsw_pkg::PC_OFFSET;
            end
            addr_in = a;
            oob_in  = ({1'b0, a} >= MEM_BYTES);
            hiok_in = (a[31:2] != 30'(MEM_WORDS - 1));
            mm_ra0  = a[AW+1:2];
            mm_ra1  = a[AW+1:2] + 1'b1;
            if (!ins_ff[24]) begin
               rf_we = 1'b1;
               rf_wa = ins_ff[19:16];
               rf_wd = moved_in;
            end
            state_in = S_MEM;
         end
         S_MEM: begin
            rf_we = 1'b1;
            rf_wa = ins_ff[15:12];
            rf_wd = rdv;
            dv_in = rdv;
            nb_in = (ins_ff[15:12] == ins_ff[19:16]) ? rdv :
                    (ins_ff[24] ? base_ff : moved_ff);
            hiwr_in = (hi & (32'hFFFF_FFFF << sh)) | (old_ff >> (6'd32 - sh));
            state_in = S_DONE;
            if (!is_load && !oob_ff) begin
               mm_we = 1'b1;
               mm_wd = (sh == 6'd0) ? old_ff :
                       ((lo & ~(32'hFFFF_FFFF << sh)) | (old_ff << sh));
               if (sh != 6'd0 && hiok_ff) begin
                  state_in = S_HI;
               end
            end
         end
         S_HI: begin
            mm_we = 1'b1;
            mm_wa = addr_ff[AW+1:2] + 1'b1;
            mm_wd = hiwr_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rv_in   = 1'b1;
               rdv_in  = dv_ff;
               rea_in  = addr_ff;
               rnb_in  = nb_ff;
               roob_in = oob_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
      ins_ff   <= ins_in;
      off_ff   <= off_in;
      base_ff  <= base_in;
      old_ff   <= old_in;
      moved_ff <= moved_in;
      addr_ff  <= addr_in;
      oob_ff   <= oob_in;
      hiok_ff  <= hiok_in;
      dv_ff    <= dv_in;
      nb_ff    <= nb_in;
      hiwr_ff  <= hiwr_in;
      rdv_ff   <= rdv_in;
      rea_ff   <= rea_in;
      rnb_ff   <= rnb_in;
      roob_ff  <= roob_in;
   end

endmodule

`default_nettype wire

### hw/rtl/lsw_ram.sv
`default_nettype none

module lsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

`default_nettype wire

### hw/rtl/lsw_check.sv
`default_nettype none

module lsw_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_dest_value,
   input wire logic [31:0] rsp_new_base,
   input wire logic        rsp_out_of_bounds
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dest_value) && $stable(rsp_new_base)
         && $stable(rsp_out_of_bounds))
      else $error("rsp word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while a word is in flight");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req taken during clearing pass");

endmodule

bind load_store_word_unit_top lsw_check u_lsw_check (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_dest_value(rsp.dest_value),
   .rsp_new_base(rsp.new_base),
   .rsp_out_of_bounds(rsp.out_of_bounds)
);

`default_nettype wire
